>>> rtl/tcli_pkg.sv
// shared types and constants of the tone curve interpolator
package tcli_pkg;

  localparam int unsigned LutSize   = 1024;
  localparam int unsigned SampleW   = 18;
  localparam int unsigned ValueW    = 17;
  localparam int unsigned EntryIdxW = 10;
  localparam int unsigned ChanW     = 2;
  localparam int unsigned FracW     = 16;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 4;

  localparam logic [ValueW-1:0] OneQ16   = ValueW'(65536);
  localparam logic [ChanW-1:0]  ChanNone = ChanW'(3);

  typedef enum logic {
    OP_APPLY = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef enum logic [ChanW-1:0] {
    CURVE_RED    = 2'd0,
    CURVE_GREEN  = 2'd1,
    CURVE_BLUE   = 2'd2,
    CURVE_MASTER = 2'd3
  } curve_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_CURVES_ACTIVE = 1'b0,
    CFG_BYPASS_MASK   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                     valid;
    logic                     wr;
    logic                     wen;
    logic [ChanW-1:0]         curve;
    logic                     ch_en;
    logic                     m_en;
    logic [EntryIdxW-1:0]     widx;
    logic [ValueW-1:0]        wval;
    logic signed [SampleW-1:0] v;
  } item_t;

endpackage

>>> rtl/tone_curve_lut_interpolator.sv
// Tone curve interpolator: takes one item per clock while the pipeline advances,
// apply or table write. An apply item goes through its channel curve and then the
// master curve, each a four-stage unit around a table memory read at two adjacent
// entries in the same cycle; the result passes the input register, both curve units
// and the output register. A table write travels down the same pipeline and lands at
// the read stage of its table, so every item sees the table writes that came
// before it and none that came after. The input side keeps accepting while a
// result waits at the output, until the next result reaches the end of the pipeline.
// Table entries must be written before any sample looks them up.
module tone_curve_lut_interpolator #(
  parameter int unsigned LUT_SIZE = tcli_pkg::LutSize
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tcli_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [tcli_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic [tcli_pkg::ChanW-1:0]          channel_i,
  input  logic [tcli_pkg::ChanW-1:0]          target_curve_i,
  input  logic [tcli_pkg::EntryIdxW-1:0]      entry_index_i,
  input  logic [tcli_pkg::ValueW-1:0]         entry_value_i,
  input  logic signed [tcli_pkg::SampleW-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tcli_pkg::SampleW-1:0] result_sample_o
);

  // configuration registers
  logic                          active_q, active_d;
  logic [tcli_pkg::CfgDataW-1:0] mask_q, mask_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    active_d = active_q;
    mask_d   = mask_q;
    if (cfg_valid_i) begin
      case (tcli_pkg::cfg_reg_e'(cfg_index_i))
        tcli_pkg::CFG_CURVES_ACTIVE: active_d = cfg_data_i[0];
        tcli_pkg::CFG_BYPASS_MASK:   mask_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      mask_q   <= '1;
    end else begin
      active_q <= active_d;
      mask_q   <= mask_d;
    end
  end

  // pipeline flow
  tcli_pkg::item_t item0_q, item0_d, item1, item2;
  logic            adv;
  logic            out_valid_q, out_valid_d;
  logic signed [tcli_pkg::SampleW-1:0] result_q;
  logic            load_out;

  assign adv        = ~(item2.valid & ~item2.wr) | ~out_valid_q | out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    item0_d       = '0;
    item0_d.valid = in_valid_i;
    item0_d.wr    = (tcli_pkg::opcode_e'(opcode_i) == tcli_pkg::OP_WRITE);
    item0_d.wen   = item0_d.wr & (32'(entry_index_i) < LUT_SIZE);
    item0_d.curve = item0_d.wr ? target_curve_i : channel_i;
    item0_d.ch_en = active_q & (channel_i != tcli_pkg::ChanNone) & ~mask_q[channel_i];
    item0_d.m_en  = active_q & ~mask_q[3];
    item0_d.widx  = entry_index_i;
    item0_d.wval  = (entry_value_i > tcli_pkg::OneQ16) ? tcli_pkg::OneQ16 : entry_value_i;
    item0_d.v     = sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item0_q <= '0;
    end else if (adv) begin
      item0_q <= item0_d;
    end
  end

  tcli_curve #(
    .LUT_SIZE  (LUT_SIZE),
    .IS_MASTER (1'b0)
  ) u_chan_curve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item0_q),
    .item_o (item1)
  );

  tcli_curve #(
    .LUT_SIZE  (LUT_SIZE),
    .IS_MASTER (1'b1)
  ) u_master_curve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item1),
    .item_o (item2)
  );

  // output register
  assign load_out = adv & item2.valid & ~item2.wr;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      result_q <= item2.v;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_sample_o = result_q;

endmodule

>>> rtl/tcli_curve.sv
// one curve stage: table memory, index scaling, two-entry read and interpolation
module tcli_curve #(
  parameter int unsigned LUT_SIZE  = tcli_pkg::LutSize,
  parameter bit          IS_MASTER = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  tcli_pkg::item_t item_i,
  output tcli_pkg::item_t item_o
);

  localparam int unsigned NumTables = IS_MASTER ? 1 : 3;
  localparam int unsigned Depth     = NumTables * LUT_SIZE;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned IdxW      = $clog2(LUT_SIZE);
  localparam int unsigned PosW      = tcli_pkg::ValueW + IdxW;
  localparam int unsigned ProdW     = tcli_pkg::SampleW + tcli_pkg::ValueW;
  localparam int unsigned SumW      = tcli_pkg::SampleW + 1;
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(LUT_SIZE - 1);
  localparam logic [AddrW-1:0] Base1   = AddrW'(LUT_SIZE);
  localparam logic [AddrW-1:0] Base2   = AddrW'(2 * LUT_SIZE);

  logic [tcli_pkg::ValueW-1:0] mem_q [Depth];

  // stage a: clamp and scale
  tcli_pkg::item_t             item_a_q;
  logic [IdxW-1:0]             idx_a_q, idx_a_d;
  logic [tcli_pkg::FracW-1:0]  frac_a_q, frac_a_d;
  logic                        last_a_q, last_a_d;
  logic [tcli_pkg::ValueW-1:0] xc;
  logic [PosW-1:0]             pos;

  always_comb begin
    if (item_i.v[tcli_pkg::SampleW-1]) begin
      xc = '0;
    end else if (item_i.v[tcli_pkg::ValueW-1:0] > tcli_pkg::OneQ16) begin
      xc = tcli_pkg::OneQ16;
    end else begin
      xc = item_i.v[tcli_pkg::ValueW-1:0];
    end
    pos      = PosW'(xc) * PosW'(LastIdx);
    idx_a_d  = pos[tcli_pkg::FracW +: IdxW];
    frac_a_d = pos[tcli_pkg::FracW-1:0];
    last_a_d = (idx_a_d == LastIdx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_a_q <= '0;
    end else if (adv_i) begin
      item_a_q <= item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      idx_a_q  <= idx_a_d;
      frac_a_q <= frac_a_d;
      last_a_q <= last_a_d;
    end
  end

  // table access: write items land here in stream order
  logic [AddrW-1:0] base, rd_addr0, rd_addr1, wr_addr;
  logic [IdxW-1:0]  idx_next;
  logic             match, wr_en;

  always_comb begin
    base = '0;
    if (!IS_MASTER) begin
      case (tcli_pkg::curve_e'(item_a_q.curve))
        tcli_pkg::CURVE_GREEN: base = Base1;
        tcli_pkg::CURVE_BLUE:  base = Base2;
        default:               base = '0;
      endcase
    end
    idx_next = last_a_q ? idx_a_q : IdxW'(idx_a_q + 1'b1);
    rd_addr0 = base + AddrW'(idx_a_q);
    rd_addr1 = base + AddrW'(idx_next);
    wr_addr  = base + AddrW'(IdxW'(item_a_q.widx));
    match    = IS_MASTER ? (item_a_q.curve == tcli_pkg::CURVE_MASTER)
                         : (item_a_q.curve != tcli_pkg::CURVE_MASTER);
    wr_en    = adv_i & item_a_q.valid & item_a_q.wr & item_a_q.wen & match;
  end

  // stage b: registered read data
  tcli_pkg::item_t             item_b_q;
  logic [tcli_pkg::FracW-1:0]  frac_b_q;
  logic [tcli_pkg::ValueW-1:0] rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= item_a_q.wval;
    end
    if (adv_i) begin
      rd0_q    <= mem_q[rd_addr0];
      rd1_q    <= mem_q[rd_addr1];
      frac_b_q <= frac_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_b_q <= '0;
    end else if (adv_i) begin
      item_b_q <= item_a_q;
    end
  end

  // stage c: slope times fraction
  tcli_pkg::item_t                  item_c_q;
  logic [tcli_pkg::ValueW-1:0]      a_c_q;
  logic signed [ProdW-1:0]          prod_c_q, prod_c_d;
  logic signed [tcli_pkg::SampleW-1:0] diff;

  always_comb begin
    diff     = $signed({1'b0, rd1_q}) - $signed({1'b0, rd0_q});
    prod_c_d = diff * $signed({1'b0, frac_b_q});
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_c_q    <= rd0_q;
      prod_c_q <= prod_c_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_c_q <= '0;
    end else if (adv_i) begin
      item_c_q <= item_b_q;
    end
  end

  // stage d: floor add and curve select
  tcli_pkg::item_t          item_d_q, item_d_d;
  logic signed [ProdW-1:0]  shifted;
  logic signed [SumW-1:0]   sum;
  logic                     en;

  always_comb begin
    shifted  = prod_c_q >>> tcli_pkg::FracW;
    sum      = $signed({2'b00, a_c_q}) + SumW'(shifted);
    en       = ~item_c_q.wr & (IS_MASTER ? item_c_q.m_en : item_c_q.ch_en);
    item_d_d = item_c_q;
    if (en) begin
      item_d_d.v = sum[tcli_pkg::SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_d_q <= '0;
    end else if (adv_i) begin
      item_d_q <= item_d_d;
    end
  end

  assign item_o = item_d_q;

endmodule

>>> rtl/tcli_checker.sv
// port-level checks of the tone curve interpolator and their bind
module tcli_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_ready_o,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [tcli_pkg::SampleW-1:0] result_sample_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_sample_o))
    else $error("result changed while stalled");

  // input side never blocks when the output slot is free or draining
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input blocked with free output");

  // nothing shows during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result during reset");

  // register writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("register write refused");

endmodule

bind tone_curve_lut_interpolator tcli_checker u_tcli_checker (.*);

>>> sim/testbench.sv
// self-checking testbench for the channel-then-master tone curve interpolator
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned LutSize   = tcli_pkg::LutSize;
  localparam int unsigned SampleW   = tcli_pkg::SampleW;
  localparam int unsigned ValueW    = tcli_pkg::ValueW;
  localparam int unsigned EntryIdxW = tcli_pkg::EntryIdxW;
  localparam int unsigned ChanW     = tcli_pkg::ChanW;
  localparam int unsigned FracW     = tcli_pkg::FracW;
  localparam int unsigned CfgIndexW = tcli_pkg::CfgIndexW;
  localparam int unsigned CfgDataW  = tcli_pkg::CfgDataW;

  localparam int PLAN = 0;
  localparam int PRED = 1;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 24;
  localparam int LongStall = 300;
  localparam int PhaseItems = 40;

  typedef struct packed {
    tcli_pkg::opcode_e         op;
    logic [ChanW-1:0]          chan;
    logic [ChanW-1:0]          target;
    logic [EntryIdxW-1:0]      idx;
    logic [ValueW-1:0]         val;
    logic signed [SampleW-1:0] smp;
  } tone_item_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CfgIndexW-1:0]        cfg_index_i = '0;
  logic [CfgDataW-1:0]         cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic                        opcode_i = 1'b0;
  logic [ChanW-1:0]            channel_i = '0;
  logic [ChanW-1:0]            target_curve_i = '0;
  logic [EntryIdxW-1:0]        entry_index_i = '0;
  logic [ValueW-1:0]           entry_value_i = '0;
  logic signed [SampleW-1:0]   sample_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [SampleW-1:0]   result_sample_o;

  logic [ValueW-1:0]           lut_bank [2][4][LutSize];
  bit                          lut_written [4][LutSize];
  logic                        cur_active = 1'b0;
  logic [3:0]                  cur_bypass = 4'hF;
  bit                          plan_hole = 1'b0;
  int                          hole_curve = 0;
  int                          hole_idx = 0;

  tone_item_t                  pend_items [$];
  logic signed [SampleW-1:0]   toned_q [$];
  tone_item_t                  on_bus;
  tone_item_t                  nxt_item;
  logic signed [SampleW-1:0]   want_sample;

  int                          send_idle_pct = 0;
  int                          rx_stall_pct = 0;
  int                          stall_req = 0;
  int                          stall_seen = 0;
  int                          stall_left = 0;
  int                          err_count = 0;
  int                          cycle_count = 0;

  tone_curve_lut_interpolator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .channel_i      (channel_i),
    .target_curve_i (target_curve_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_sample_o(result_sample_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [ValueW-1:0] clip_entry(logic [ValueW-1:0] v);
    return (v > tcli_pkg::OneQ16) ? tcli_pkg::OneQ16 : v;
  endfunction

  function automatic void note_read(int bank, int curve, int i);
    if (bank == PLAN && !lut_written[curve][i] && !plan_hole) begin
      plan_hole = 1'b1;
      hole_curve = curve;
      hole_idx = i;
    end
  endfunction

  function automatic logic signed [SampleW-1:0] curve_lookup(int bank, int curve,
                                                             logic signed [SampleW-1:0] x);
    longint xc;
    longint pos;
    longint acc;
    int idx;
    int frac;
    if (x < 0) xc = 0;
    else if (x > 65536) xc = 65536;
    else xc = x;
    pos = xc * (longint'(LutSize) - 1);
    idx = int'(pos >>> FracW);
    frac = int'(pos & 64'hFFFF);
    if (idx >= int'(LutSize) - 1) begin
      note_read(bank, curve, LutSize - 1);
      return SampleW'(lut_bank[bank][curve][LutSize-1]);
    end
    note_read(bank, curve, idx);
    note_read(bank, curve, idx + 1);
    acc = longint'(lut_bank[bank][curve][idx]) * (65536 - frac)
        + longint'(lut_bank[bank][curve][idx+1]) * frac;
    return SampleW'(acc >>> FracW);
  endfunction

  function automatic logic signed [SampleW-1:0] tone_sample(int bank, logic [ChanW-1:0] chan,
                                                            logic signed [SampleW-1:0] s);
    logic signed [SampleW-1:0] v;
    v = s;
    if (cur_active) begin
      if (chan != tcli_pkg::ChanNone && !cur_bypass[chan]) v = curve_lookup(bank, chan, v);
      if (!cur_bypass[tcli_pkg::CURVE_MASTER]) begin
        v = curve_lookup(bank, tcli_pkg::CURVE_MASTER, v);
      end
    end
    return v;
  endfunction

  function automatic logic [ValueW-1:0] rand_entry();
    case ($urandom_range(9))
      0: return '0;
      1: return tcli_pkg::OneQ16;
      2: return ValueW'($urandom_range(131071, 65537));
      default: return ValueW'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(9))
      0, 1: return SampleW'($urandom);
      2: begin
        case ($urandom_range(3))
          0: return -SampleW'(131072);
          1: return SampleW'(131071);
          2: return '0;
          default: return SampleW'(65536);
        endcase
      end
      default: return SampleW'(int'($urandom_range(72000)) - 4000);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic signed [SampleW-1:0] got,
                                 logic signed [SampleW-1:0] want);
    err_count++;
    if (err_count <= 100) $display("mismatch: %s got %0d expected %0d", what, got, want);
  endtask

  task automatic plan_write(logic [ChanW-1:0] curve, logic [EntryIdxW-1:0] idx,
                            logic [ValueW-1:0] val);
    tone_item_t it;
    it.op = tcli_pkg::OP_WRITE;
    it.chan = ChanW'($urandom);
    it.target = curve;
    it.idx = idx;
    it.val = val;
    it.smp = SampleW'($urandom);
    pend_items.push_back(it);
    lut_bank[PLAN][curve][idx] = clip_entry(val);
    lut_written[curve][idx] = 1'b1;
  endtask

  // fill every entry that this sample will look up before it is sent
  task automatic plan_apply(logic [ChanW-1:0] chan, logic signed [SampleW-1:0] smp);
    tone_item_t it;
    plan_hole = 1'b1;
    while (plan_hole) begin
      plan_hole = 1'b0;
      void'(tone_sample(PLAN, chan, smp));
      if (plan_hole) plan_write(ChanW'(hole_curve), EntryIdxW'(hole_idx), rand_entry());
    end
    it.op = tcli_pkg::OP_APPLY;
    it.chan = chan;
    it.target = ChanW'($urandom);
    it.idx = EntryIdxW'($urandom);
    it.val = ValueW'($urandom);
    it.smp = smp;
    pend_items.push_back(it);
  endtask

  task automatic plan_random(int count);
    repeat (count) begin
      if ($urandom_range(99) < 30) begin
        plan_write(ChanW'($urandom_range(3)), EntryIdxW'($urandom_range(LutSize - 1)),
                   rand_entry());
      end else begin
        plan_apply(ChanW'($urandom_range(3)), rand_sample());
      end
    end
  endtask

  task automatic write_cfg(tcli_pkg::cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      tcli_pkg::CFG_CURVES_ACTIVE: cur_active = data[0];
      tcli_pkg::CFG_BYPASS_MASK:   cur_bypass = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pend_items.size() != 0 || in_valid_i || toned_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("** tone_curve_lut_interpolator: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      stall_left <= LongStall;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // input driver and acceptance-time prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (on_bus.op == tcli_pkg::OP_WRITE) begin
          lut_bank[PRED][on_bus.target][on_bus.idx] = clip_entry(on_bus.val);
        end else begin
          toned_q.push_back(tone_sample(PRED, on_bus.chan, on_bus.smp));
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (pend_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_item = pend_items.pop_front();
          on_bus = nxt_item;
          in_valid_i <= 1'b1;
          opcode_i <= nxt_item.op;
          channel_i <= nxt_item.chan;
          target_curve_i <= nxt_item.target;
          entry_index_i <= nxt_item.idx;
          entry_value_i <= nxt_item.val;
          sample_i <= nxt_item.smp;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (toned_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected", result_sample_o, '0);
        end else begin
          want_sample = toned_q.pop_front();
          if (result_sample_o !== want_sample) begin
            report_mismatch("result_sample", result_sample_o, want_sample);
          end
        end
      end
      out_ready_i <= (stall_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(tcli_pkg::CFG_CURVES_ACTIVE, 4'd1);
    write_cfg(tcli_pkg::CFG_BYPASS_MASK, 4'd0);
    plan_write(tcli_pkg::CURVE_RED, '0, '0);
    plan_write(tcli_pkg::CURVE_RED, EntryIdxW'(LutSize - 1), tcli_pkg::OneQ16);
    plan_write(tcli_pkg::CURVE_MASTER, '0, ValueW'(131071));
    plan_write(tcli_pkg::CURVE_MASTER, EntryIdxW'(LutSize - 1), tcli_pkg::OneQ16 + 1'b1);
    plan_write(tcli_pkg::CURVE_GREEN, EntryIdxW'(1), ValueW'(65535));
    plan_apply(tcli_pkg::CURVE_RED, -SampleW'(131072));
    plan_apply(tcli_pkg::CURVE_RED, -SampleW'(1));
    plan_apply(tcli_pkg::CURVE_RED, '0);
    plan_apply(tcli_pkg::CURVE_GREEN, SampleW'(1));
    plan_apply(tcli_pkg::CURVE_BLUE, SampleW'(65535));
    plan_apply(tcli_pkg::CURVE_RED, SampleW'(65536));
    plan_apply(tcli_pkg::CURVE_GREEN, SampleW'(65537));
    plan_apply(tcli_pkg::CURVE_BLUE, SampleW'(131071));
    plan_apply(tcli_pkg::ChanNone, SampleW'(32768));
    plan_apply(tcli_pkg::ChanNone, -SampleW'(5));
    wait_drained();

    // inactive set ignores the bypass mask
    write_cfg(tcli_pkg::CFG_CURVES_ACTIVE, 4'd0);
    plan_apply(tcli_pkg::CURVE_RED, SampleW'(40000));
    plan_apply(tcli_pkg::ChanNone, -SampleW'(131072));
    plan_apply(tcli_pkg::CURVE_BLUE, SampleW'(131071));
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_cfg(tcli_pkg::CFG_CURVES_ACTIVE, (p == 0 || p == 6) ? 4'd0 : 4'd1);
      case (p)
        0, 2: write_cfg(tcli_pkg::CFG_BYPASS_MASK, 4'hF);
        1, 4: write_cfg(tcli_pkg::CFG_BYPASS_MASK, 4'h0);
        default: write_cfg(tcli_pkg::CFG_BYPASS_MASK, CfgDataW'($urandom_range(15)));
      endcase
      case (p % 4)
        0: begin send_idle_pct <= 0;  rx_stall_pct <= 0;  end
        1: begin send_idle_pct <= 56; rx_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  rx_stall_pct <= 56; end
        default: begin send_idle_pct <= 19; rx_stall_pct <= 19; end
      endcase
      if (p == 4) begin
        stall_req <= stall_req + 1;
      end
      if (p == 5) begin
        plan_random(PhaseItems / 2);
        wait_drained();
        plan_random(PhaseItems - PhaseItems / 2);
      end else begin
        plan_random(PhaseItems);
      end
      wait_drained();
    end

    if (toned_q.size() != 0) report_mismatch("results still expected at end", '0, toned_q[0]);
    if (err_count == 0) begin
      $display("** tone_curve_lut_interpolator: PASSED **");
    end else begin
      $display("** tone_curve_lut_interpolator: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tcli_pkg.sv
rtl/tcli_curve.sv
rtl/tone_curve_lut_interpolator.sv
rtl/tcli_checker.sv
sim/testbench.sv
